>>> hw/rtl/lmdd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the line model deviation detector.
package lmdd_pkg;

  localparam int CNT_W      = 5;
  localparam int DIV_STEPS  = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_OFFSET     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RES    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_TRAVEL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TRAVEL = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DOT,
    ST_NRM,
    ST_DRAIN,
    ST_PREP,
    ST_DIV,
    ST_TSAT,
    ST_RES,
    ST_RDRAIN,
    ST_EVAL,
    ST_OVR,
    ST_FIN
  } state_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_DOT,
    MUL_NRM,
    MUL_RES,
    MUL_OVR
  } mul_op_t;

  typedef struct packed {
    logic             load;
    mul_op_t          op;
    logic             div_prep;
    logic             div_step;
    logic             tsat;
    logic             eval;
    logic             fin;
    logic [CNT_W-1:0] cnt;
  } cmd_t;

endpackage

>>> hw/rtl/lmdd_if.sv
`timescale 1ns / 1ps
// Channel interfaces for samples, results and configuration writes.
interface lmdd_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_a;
  logic signed [15:0] sample_b;
  logic signed [15:0] sample_c;
  logic signed [15:0] sample_d;
  modport source(output valid, output sample_a, output sample_b, output sample_c,
                 output sample_d, input ready);
  modport sink(input valid, input sample_a, input sample_b, input sample_c,
               input sample_d, output ready);
endinterface

interface lmdd_out_if;
  logic               valid;
  logic               ready;
  logic        [47:0] deviation;
  logic signed [31:0] travel;
  logic        [26:0] residual;
  logic               held;
  modport source(output valid, output deviation, output travel, output residual,
                 output held, input ready);
  modport sink(input valid, input deviation, input travel, input residual,
               input held, output ready);
endinterface

interface lmdd_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [lmdd_pkg::CFG_IDX_W-1:0]    index;
  logic [lmdd_pkg::CFG_DATA_W-1:0]   data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/lmdd_ctrl.sv
`timescale 1ns / 1ps
// Sequencer that steps the datapath through one item.
module lmdd_ctrl #(
  parameter int CHANNELS = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           out_free,
  output lmdd_pkg::cmd_t cmd
);

  localparam logic [lmdd_pkg::CNT_W-1:0] LAST_CH  = lmdd_pkg::CNT_W'(CHANNELS - 1);
  localparam logic [lmdd_pkg::CNT_W-1:0] LAST_DIV = lmdd_pkg::CNT_W'(lmdd_pkg::DIV_STEPS - 1);

  lmdd_pkg::state_t             state;
  lmdd_pkg::state_t             state_next;
  logic [lmdd_pkg::CNT_W-1:0]   cnt;
  logic [lmdd_pkg::CNT_W-1:0]   cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lmdd_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.op     = lmdd_pkg::MUL_NONE;
    cmd.cnt    = cnt;
    case (state)
      lmdd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          state_next = lmdd_pkg::ST_DOT;
        end
      end
      lmdd_pkg::ST_DOT: begin
        cmd.op = lmdd_pkg::MUL_DOT;
        if (cnt == LAST_CH) begin
          cnt_next   = '0;
          state_next = lmdd_pkg::ST_NRM;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      lmdd_pkg::ST_NRM: begin
        cmd.op = lmdd_pkg::MUL_NRM;
        if (cnt == LAST_CH) begin
          cnt_next   = '0;
          state_next = lmdd_pkg::ST_DRAIN;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      lmdd_pkg::ST_DRAIN: begin
        state_next = lmdd_pkg::ST_PREP;
      end
      lmdd_pkg::ST_PREP: begin
        cmd.div_prep = 1'b1;
        cnt_next     = '0;
        state_next   = lmdd_pkg::ST_DIV;
      end
      lmdd_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == LAST_DIV) begin
          cnt_next   = '0;
          state_next = lmdd_pkg::ST_TSAT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      lmdd_pkg::ST_TSAT: begin
        cmd.tsat   = 1'b1;
        cnt_next   = '0;
        state_next = lmdd_pkg::ST_RES;
      end
      lmdd_pkg::ST_RES: begin
        cmd.op = lmdd_pkg::MUL_RES;
        if (cnt == LAST_CH) begin
          cnt_next   = '0;
          state_next = lmdd_pkg::ST_RDRAIN;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      lmdd_pkg::ST_RDRAIN: begin
        state_next = lmdd_pkg::ST_EVAL;
      end
      lmdd_pkg::ST_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = lmdd_pkg::ST_OVR;
      end
      lmdd_pkg::ST_OVR: begin
        cmd.op     = lmdd_pkg::MUL_OVR;
        state_next = lmdd_pkg::ST_FIN;
      end
      lmdd_pkg::ST_FIN: begin
        if (out_free) begin
          cmd.fin    = 1'b1;
          state_next = lmdd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lmdd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/lmdd_dp.sv
`timescale 1ns / 1ps
// Datapath: shared multiplier, accumulators, serial divider and result register.
module lmdd_dp #(
  parameter int CHANNELS = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  lmdd_pkg::cmd_t     cmd,
  input  logic signed [15:0] sample_a,
  input  logic signed [15:0] sample_b,
  input  logic signed [15:0] sample_c,
  input  logic signed [15:0] sample_d,
  input  logic        [63:0] offset_vector,
  input  logic        [63:0] direction_vector,
  input  logic        [26:0] max_residual,
  input  logic signed [31:0] min_travel,
  input  logic signed [31:0] max_travel,
  output logic               out_free,
  output logic               out_valid,
  input  logic               out_ready,
  output logic        [47:0] deviation,
  output logic signed [31:0] travel,
  output logic        [26:0] residual,
  output logic               held
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic signed [31:0] T_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] T_MIN = 32'sh8000_0000;

  logic signed [15:0] smp   [4];
  logic signed [15:0] off_v [CHANNELS];
  logic signed [15:0] dir_v [CHANNELS];
  logic signed [16:0] d     [CHANNELS];

  logic [IDX_W-1:0]   idx;
  logic signed [15:0] dir_sel;
  logic signed [16:0] d_sel;
  logic        [15:0] dir_mag;

  logic signed [33:0] mul_a;
  logic signed [18:0] mul_b;
  logic signed [52:0] prod;
  logic signed [52:0] p;
  logic signed [16:0] p_d;
  lmdd_pkg::mul_op_t  p_op;

  logic signed [34:0] dot;
  logic        [32:0] n2;
  logic        [17:0] n1;
  logic        [50:0] racc;

  logic        [34:0] dot_mag;
  logic               ovf_c;
  logic               neg;
  logic               zero_dir;
  logic               ovf;
  logic        [32:0] rem;
  logic        [31:0] qn;
  logic        [33:0] trial;
  logic               ge;

  logic signed [31:0] t;
  logic signed [49:0] rdiff;
  logic        [49:0] rmag;

  logic        [30:0] res_raw;
  logic        [26:0] res_sat;
  logic               eq;
  logic               in_range;
  logic               below;
  logic               above;
  logic signed [32:0] diff_lo;
  logic signed [32:0] diff_hi;

  logic        [26:0] res;
  logic        [34:0] excess;
  logic        [31:0] ovr;
  logic               use_ovr;
  logic               set;
  logic        [47:0] status_c;
  logic        [47:0] last_deviation;

  assign smp[0] = sample_a;
  assign smp[1] = sample_b;
  assign smp[2] = sample_c;
  assign smp[3] = sample_d;

  for (genvar gi = 0; gi < CHANNELS; gi++) begin : g_ch
    assign off_v[gi] = offset_vector[16*gi +: 16];
    assign dir_v[gi] = direction_vector[16*gi +: 16];
  end

  assign idx     = cmd.cnt[IDX_W-1:0];
  assign dir_sel = dir_v[idx];
  assign d_sel   = d[idx];
  assign dir_mag = dir_sel[15] ? 16'(-dir_sel) : 16'(dir_sel);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      lmdd_pkg::MUL_DOT: begin
        mul_a = {{17{d_sel[16]}}, d_sel};
        mul_b = {{3{dir_sel[15]}}, dir_sel};
      end
      lmdd_pkg::MUL_NRM: begin
        mul_a = {{18{dir_sel[15]}}, dir_sel};
        mul_b = {{3{dir_sel[15]}}, dir_sel};
      end
      lmdd_pkg::MUL_RES: begin
        mul_a = {{2{t[31]}}, t};
        mul_b = {{3{dir_sel[15]}}, dir_sel};
      end
      lmdd_pkg::MUL_OVR: begin
        mul_a = {2'b00, ovr};
        mul_b = {1'b0, n1};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  assign rdiff = $signed({{5{p_d[16]}}, p_d, 28'd0}) - $signed(p[49:0]);
  assign rmag  = rdiff[49] ? 50'(-rdiff) : 50'(rdiff);

  assign dot_mag = dot[34] ? 35'(-dot) : 35'(dot);
  assign ovf_c   = {2'b00, dot_mag} >= {n2, 4'd0};
  assign trial   = {rem, qn[31]};
  assign ge      = trial >= {1'b0, n2};

  assign res_raw  = racc[50:20];
  assign res_sat  = (|res_raw[30:27]) ? '1 : res_raw[26:0];
  assign eq       = res_sat == max_residual;
  assign in_range = (t > min_travel) && (t < max_travel) && !eq;
  assign below    = (t < min_travel) && !eq;
  assign above    = (t > max_travel) && !eq;
  assign diff_lo  = {min_travel[31], min_travel} - {t[31], t};
  assign diff_hi  = {t[31], t} - {max_travel[31], max_travel};

  assign status_c = (use_ovr ? 48'(p[52:12]) : 48'd0) + 48'(excess);
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_op           <= lmdd_pkg::MUL_NONE;
      out_valid      <= 1'b0;
      last_deviation <= '0;
    end else begin
      p_op <= cmd.op;
      if (cmd.fin) begin
        out_valid <= 1'b1;
        if (set) begin
          last_deviation <= status_c;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op != lmdd_pkg::MUL_NONE) begin
      p   <= prod;
      p_d <= d_sel;
    end
    if (cmd.load) begin
      for (int i = 0; i < CHANNELS; i++) begin
        d[i] <= $signed({smp[i][15], smp[i]}) - $signed({off_v[i][15], off_v[i]});
      end
      dot  <= '0;
      n2   <= '0;
      n1   <= '0;
      racc <= '0;
    end else begin
      if (cmd.op == lmdd_pkg::MUL_NRM) begin
        n1 <= n1 + 18'(dir_mag);
      end
      case (p_op)
        lmdd_pkg::MUL_DOT: dot  <= dot + $signed(p[34:0]);
        lmdd_pkg::MUL_NRM: n2   <= n2 + p[32:0];
        lmdd_pkg::MUL_RES: racc <= racc + 51'(rmag);
        default: ;
      endcase
    end
    if (cmd.div_prep) begin
      neg      <= dot[34];
      zero_dir <= n2 == '0;
      ovf      <= ovf_c;
      rem      <= 33'(dot_mag >> 4);
      qn       <= {dot_mag[3:0], 28'd0};
    end
    if (cmd.div_step) begin
      rem <= ge ? 33'(trial - {1'b0, n2}) : trial[32:0];
      qn  <= {qn[30:0], ge};
    end
    if (cmd.tsat) begin
      if (zero_dir) begin
        t <= '0;
      end else if (ovf) begin
        t <= neg ? T_MIN : T_MAX;
      end else if (neg) begin
        t <= (qn > 32'h8000_0000) ? T_MIN : $signed(-qn);
      end else begin
        t <= qn[31] ? T_MAX : $signed(qn);
      end
    end
    if (cmd.eval) begin
      res     <= res_sat;
      excess  <= (res_sat > max_residual) ? {res_sat - max_residual, 8'd0} : '0;
      ovr     <= below ? diff_lo[31:0] : diff_hi[31:0];
      use_ovr <= !in_range && (below || above);
      set     <= in_range || below || above;
    end
    if (cmd.fin) begin
      deviation <= set ? status_c : last_deviation;
      travel    <= t;
      residual  <= res;
      held      <= !set;
    end
  end

endmodule

>>> hw/rtl/line_model_deviation_detector.sv
`timescale 1ns / 1ps
// Top level of the line model deviation detector.
//
//   channel   role    carries
//   cfg       sink    register index and 64-bit write data
//   samples   sink    four signed 16-bit channel samples
//   results   source  deviation, travel, residual, held
//
// Items are taken one at a time, with no new samples transfer until the item in
// progress is finished; the 32-step bit-serial travel divider and the single
// shared multiplier (dot product, squared norm, residual, overshoot) do the work.
// Reset clears the sequencer, the result valid flag, the kept status and all
// configuration registers. A finished result waits in the output register while
// the next samples transfer is taken; a stalled result stalls only the last step.
module line_model_deviation_detector #(
  parameter int CHANNELS = 4
) (
  input  logic        clk,
  input  logic        rst,
  lmdd_cfg_if.sink    cfg,
  lmdd_in_if.sink     samples,
  lmdd_out_if.source  results
);

  logic        [63:0] offset_vector;
  logic        [63:0] direction_vector;
  logic        [26:0] max_residual;
  logic signed [31:0] min_travel;
  logic signed [31:0] max_travel;

  lmdd_pkg::cmd_t cmd;
  logic           out_free;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_vector    <= '0;
      direction_vector <= '0;
      max_residual     <= '0;
      min_travel       <= '0;
      max_travel       <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        lmdd_pkg::REG_OFFSET:     offset_vector    <= cfg.data;
        lmdd_pkg::REG_DIRECTION:  direction_vector <= cfg.data;
        lmdd_pkg::REG_MAX_RES:    max_residual     <= cfg.data[26:0];
        lmdd_pkg::REG_MIN_TRAVEL: min_travel       <= $signed(cfg.data[31:0]);
        lmdd_pkg::REG_MAX_TRAVEL: max_travel       <= $signed(cfg.data[31:0]);
        default: ;
      endcase
    end
  end

  lmdd_ctrl #(
    .CHANNELS(CHANNELS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (samples.ready),
    .out_free (out_free),
    .cmd      (cmd)
  );

  lmdd_dp #(
    .CHANNELS(CHANNELS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sample_a         (samples.sample_a),
    .sample_b         (samples.sample_b),
    .sample_c         (samples.sample_c),
    .sample_d         (samples.sample_d),
    .offset_vector    (offset_vector),
    .direction_vector (direction_vector),
    .max_residual     (max_residual),
    .min_travel       (min_travel),
    .max_travel       (max_travel),
    .out_free         (out_free),
    .out_valid        (results.valid),
    .out_ready        (results.ready),
    .deviation        (results.deviation),
    .travel           (results.travel),
    .residual         (results.residual),
    .held             (results.held)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    samples.valid && samples.ready |=> !samples.ready)
    else $error("samples ready while an item is in progress");

  a_fin_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.fin |-> out_free)
    else $error("result loaded while the output register is occupied");

  a_fin_gives_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.fin |=> results.valid)
    else $error("finished item did not raise result valid");

  a_idle_no_multiply: assert property (@(posedge clk) disable iff (rst)
    samples.ready |-> cmd.op == lmdd_pkg::MUL_NONE)
    else $error("multiplier issued while waiting for samples");

endmodule

>>> sim/lmdd_checker.sv
`timescale 1ns / 1ps
// Result predictor and scoreboard for the line model deviation detector.
module lmdd_checker #(
  parameter int CHANNELS = 4
) (
  input  logic clk,
  input  logic rst,
  lmdd_cfg_if  cfg,
  lmdd_in_if   samples,
  lmdd_out_if  results,
  output int   mismatches,
  output int   pending,
  output int   checked,
  output int   held_seen
);

  typedef struct packed {
    logic        [47:0] deviation;
    logic signed [31:0] travel;
    logic        [26:0] residual;
    logic               held;
  } fit_t;

  localparam longint RES_MAX    = 64'h7FF_FFFF;
  localparam longint DEV_MAX    = 64'hFFFF_FFFF_FFFF;
  localparam longint TRAVEL_MAX = 64'h7FFF_FFFF;
  localparam longint TRAVEL_MIN = -longint'(64'h8000_0000);

  logic        [63:0] off_r;
  logic        [63:0] dir_r;
  logic        [26:0] res_lim;
  logic signed [31:0] lo_r;
  logic signed [31:0] hi_r;
  logic        [47:0] kept_status;
  fit_t               fit_q[$];
  fit_t               want;
  fit_t               got;

  // Projects one sample vector onto the configured line and updates the kept status.
  function automatic fit_t fit_line(input logic [63:0] smp);
    longint dir[4];
    longint dlt[4];
    longint dot, n2, n1, t, term, racc, res, lim, excess, status, lo, hi;
    logic   set;
    fit_t   r;
    dot = 0;
    n2 = 0;
    n1 = 0;
    racc = 0;
    status = 0;
    set = 1'b0;
    lo = lo_r;
    hi = hi_r;
    lim = longint'(res_lim);
    for (int i = 0; i < CHANNELS; i++) begin
      dir[i] = longint'($signed(dir_r[16*i +: 16]));
      dlt[i] = longint'($signed(smp[16*i +: 16])) - longint'($signed(off_r[16*i +: 16]));
      dot += dir[i] * dlt[i];
      n2 += dir[i] * dir[i];
      n1 += (dir[i] < 0) ? -dir[i] : dir[i];
    end
    if (n2 == 0) begin
      t = 0;
    end else begin
      t = (dot <<< 28) / n2;
      if (t > TRAVEL_MAX) t = TRAVEL_MAX;
      if (t < TRAVEL_MIN) t = TRAVEL_MIN;
    end
    for (int i = 0; i < CHANNELS; i++) begin
      term = (dlt[i] <<< 28) - dir[i] * t;
      racc += (term < 0) ? -term : term;
    end
    res = racc >>> 20;
    if (res > RES_MAX) res = RES_MAX;
    excess = (res > lim) ? ((res - lim) <<< 8) : 0;
    if (t > hi && res != lim) begin
      status = (((t - hi) * n1) >>> 12) + excess;
      set = 1'b1;
    end
    if (t < lo && res != lim) begin
      status = (((lo - t) * n1) >>> 12) + excess;
      set = 1'b1;
    end
    if (t > lo && t < hi && res != lim) begin
      status = excess;
      set = 1'b1;
    end
    if (set) begin
      if (status > DEV_MAX) status = DEV_MAX;
      kept_status = status[47:0];
    end
    r.deviation = kept_status;
    r.travel = t[31:0];
    r.residual = res[26:0];
    r.held = !set;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      off_r = '0;
      dir_r = '0;
      res_lim = '0;
      lo_r = '0;
      hi_r = '0;
      kept_status = '0;
      fit_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          lmdd_pkg::REG_OFFSET:     off_r = cfg.data;
          lmdd_pkg::REG_DIRECTION:  dir_r = cfg.data;
          lmdd_pkg::REG_MAX_RES:    res_lim = cfg.data[26:0];
          lmdd_pkg::REG_MIN_TRAVEL: lo_r = cfg.data[31:0];
          lmdd_pkg::REG_MAX_TRAVEL: hi_r = cfg.data[31:0];
          default: ;
        endcase
      end
      if (samples.valid && samples.ready) begin
        fit_q.push_back(fit_line({samples.sample_d, samples.sample_c,
                                  samples.sample_b, samples.sample_a}));
      end
      if (results.valid && results.ready) begin
        got = {results.deviation, results.travel, results.residual, results.held};
        checked++;
        if (got.held) held_seen++;
        if (fit_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Result transfer %0d with no sample vector waiting:", checked);
            $display("  got dev=%h trav=%0d res=%h held=%b",
                     got.deviation, got.travel, got.residual, got.held);
          end
        end else begin
          want = fit_q.pop_front();
          if (got.deviation !== want.deviation || got.travel !== want.travel ||
              got.residual !== want.residual || got.held !== want.held) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("Result transfer %0d mismatch: expected dev=%h trav=%0d res=%h held=%b",
                       checked, want.deviation, want.travel, want.residual, want.held);
              $display("  got dev=%h trav=%0d res=%h held=%b",
                       got.deviation, got.travel, got.residual, got.held);
            end
          end
        end
      end
    end
    pending = fit_q.size();
  end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// Testbench top that drives sample vectors and register writes into the deviation detector.
module tb;

  localparam int CHANNELS = 4;
  localparam int LIMIT    = 1_000_000;
  localparam int HOLD_OFF = 600;

  typedef enum {ON_AXIS, WIDE_OPEN, NEAR_OFFSET} setting_kind_t;

  logic clk;
  logic rst;
  int   sent;
  int   writes;
  int   cycles;
  bit   calm;
  int   mismatches;
  int   pending;
  int   checked;
  int   held_seen;

  lmdd_cfg_if cfg_ch();
  lmdd_in_if  smp_ch();
  lmdd_out_if res_ch();

  line_model_deviation_detector #(
    .CHANNELS(CHANNELS)
  ) uut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .samples(smp_ch),
    .results(res_ch)
  );

  lmdd_checker #(
    .CHANNELS(CHANNELS)
  ) chk (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_ch),
    .samples   (smp_ch),
    .results   (res_ch),
    .mismatches(mismatches),
    .pending   (pending),
    .checked   (checked),
    .held_seen (held_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] pack_samples(input int a, input int b, input int c,
                                               input int d);
    return {16'(d), 16'(c), 16'(b), 16'(a)};
  endfunction

  task automatic send_vec(input logic [63:0] v);
    while (!calm && $urandom_range(99) < 14) begin
      smp_ch.valid <= 1'b0;
      @(posedge clk);
    end
    smp_ch.valid <= 1'b1;
    {smp_ch.sample_d, smp_ch.sample_c, smp_ch.sample_b, smp_ch.sample_a} <= v;
    do @(posedge clk); while (!smp_ch.ready);
    sent++;
  endtask

  task automatic write_reg(input logic [lmdd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [63:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    writes++;
  endtask

  task automatic apply_setting(input logic [63:0] off, input logic [63:0] dir,
                               input logic [26:0] lim, input logic [31:0] lo,
                               input logic [31:0] hi);
    write_reg(lmdd_pkg::REG_OFFSET, off);
    write_reg(lmdd_pkg::REG_DIRECTION, dir);
    write_reg(lmdd_pkg::REG_MAX_RES, 64'(lim));
    write_reg(lmdd_pkg::REG_MIN_TRAVEL, 64'(lo));
    write_reg(lmdd_pkg::REG_MAX_TRAVEL, 64'(hi));
    cfg_ch.valid <= 1'b0;
  endtask

  // The block is idle once every sample transfer has produced its result.
  task automatic settle();
    smp_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int stall_left;
    bit stalled;
    stall_left = 0;
    stalled = 1'b0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!stalled && sent >= 300) begin
        stalled = 1'b1;
        stall_left = HOLD_OFF;
      end
      if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else if (calm) begin
        res_ch.ready <= 1'b1;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= 14);
      end
    end
  end

  initial begin
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Run stopped after %0d cycles with %0d results outstanding.", cycles, pending);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    logic [63:0]   off_v;
    logic [63:0]   dir_v;
    logic [63:0]   v;
    logic [26:0]   lim_v;
    logic [31:0]   lo_v;
    logic [31:0]   hi_v;
    logic [31:0]   swap_v;
    int            k;
    setting_kind_t kind;

    sent = 0;
    writes = 0;
    calm = 1'b0;
    rst <= 1'b1;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data <= '0;
    smp_ch.valid <= 1'b0;
    {smp_ch.sample_d, smp_ch.sample_c, smp_ch.sample_b, smp_ch.sample_a} <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // With the reset registers the direction is zero and both bounds sit on the travel.
    send_vec(64'h0);
    send_vec({4{16'h7FFF}});
    send_vec({4{16'h8000}});
    send_vec({16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001});

    settle();
    apply_setting(64'h0, 64'h1000, 27'd768, -(32'sd2 <<< 16), 32'sd5 <<< 16);
    send_vec(pack_samples(5, 1, 0, 0));
    send_vec(pack_samples(-2, 1, 0, 0));
    send_vec(pack_samples(0, 3, 0, 0));
    send_vec(pack_samples(0, 1, 0, 0));
    send_vec(pack_samples(0, 10, 0, 0));
    send_vec(pack_samples(9, 0, 0, 0));
    send_vec(pack_samples(-7, 10, -20, 7));
    send_vec(pack_samples(9, 3, 0, 0));

    settle();
    apply_setting(64'h0, 64'h0001, 27'd0, 32'h8000_0000, 32'h7FFF_FFFF);
    send_vec(pack_samples(1000, 0, 0, 0));
    send_vec(pack_samples(-1000, 0, 0, 0));
    send_vec(pack_samples(0, 5, 0, 0));

    settle();
    apply_setting(64'h0, 64'h1000, 27'd0, 32'sd5 <<< 16, -(32'sd5 <<< 16));
    send_vec(pack_samples(0, 0, 0, 0));
    send_vec(pack_samples(10, 0, 0, 0));
    send_vec(pack_samples(-10, 0, 0, 0));
    send_vec(pack_samples(5, 0, 0, 0));
    send_vec(pack_samples(-5, 0, 0, 0));

    settle();
    apply_setting({4{16'hFFFF}}, {4{16'hFFFF}}, 27'h7FF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_vec({4{16'h7FFF}});
    send_vec({4{16'h8000}});

    settle();
    apply_setting({4{16'h8000}}, {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000}, 27'd0, 32'h0, 32'h0);
    send_vec({4{16'h7FFF}});
    send_vec(64'h0);

    for (int ph = 0; ph < 8; ph++) begin
      kind = setting_kind_t'(ph % 3);
      settle();
      calm = (ph == 3);
      case (kind)
        ON_AXIS: begin
          k = $urandom_range(3);
          dir_v = '0;
          dir_v[16*k +: 16] = $urandom_range(1) ? 16'h1000 : 16'hF000;
          if ($urandom_range(1)) dir_v[16*((k+1)%4) +: 16] = 16'h1000;
          for (int i = 0; i < 4; i++) off_v[16*i +: 16] = 16'($urandom_range(16)) - 16'd8;
          lo_v = 32'(int'($urandom_range(12)) - 6) <<< 16;
          hi_v = lo_v + (32'(int'($urandom_range(8)) - 1) <<< 16);
          lim_v = 27'($urandom_range(24) * 256);
        end
        WIDE_OPEN: begin
          off_v = {$urandom, $urandom};
          dir_v = {$urandom, $urandom};
          lim_v = 27'($urandom);
          lo_v = $urandom;
          hi_v = $urandom;
          if ($urandom_range(1) && $signed(lo_v) > $signed(hi_v)) begin
            swap_v = lo_v;
            lo_v = hi_v;
            hi_v = swap_v;
          end
          if (ph == 7) begin
            lo_v = 32'h8000_0000;
            hi_v = 32'h7FFF_FFFF;
          end
        end
        default: begin
          for (int i = 0; i < 4; i++) begin
            dir_v[16*i +: 16] = ($urandom_range(3) == 0) ? 16'h0
                                : 16'(int'($urandom_range(8192)) - 4096);
            off_v[16*i +: 16] = 16'(int'($urandom_range(2000)) - 1000);
          end
          lo_v = 32'((int'($urandom_range(400)) - 200) * 65536 + int'($urandom_range(65535)));
          hi_v = lo_v + 32'($urandom_range(400) * 65536);
          lim_v = 27'($urandom_range(2_000_000));
        end
      endcase
      apply_setting(off_v, dir_v, lim_v, lo_v, hi_v);
      for (int n = 0; n < 120; n++) begin
        case (kind)
          ON_AXIS: begin
            for (int i = 0; i < 4; i++) begin
              v[16*i +: 16] = off_v[16*i +: 16] + 16'($urandom_range(24)) - 16'd12;
            end
          end
          WIDE_OPEN: v = {$urandom, $urandom};
          default: begin
            for (int i = 0; i < 4; i++) begin
              v[16*i +: 16] = off_v[16*i +: 16] + 16'($urandom_range(4000)) - 16'd2000;
            end
          end
        endcase
        if ($urandom_range(19) == 0) v = {$urandom, $urandom};
        send_vec(v);
      end
    end
    calm = 1'b0;

    smp_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (60) @(posedge clk);

    $display("Checked %0d results from %0d sample vectors after %0d register writes.",
             checked, sent, writes);
    $display("%0d results kept the previous status; one output stall lasted %0d cycles.",
             held_seen, HOLD_OFF);
    if (mismatches == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> line_model_deviation_detector.f
hw/rtl/lmdd_pkg.sv
hw/rtl/lmdd_if.sv
hw/rtl/lmdd_ctrl.sv
hw/rtl/lmdd_dp.sv
hw/rtl/line_model_deviation_detector.sv
sim/lmdd_checker.sv
sim/tb.sv
